[src/ncq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncq_pkg: shared types and constants for the nearest centroid query unit
// Item formats, command codes and the distance limits of the search.
// ----------------------------------------------------------------------------
package ncq_pkg;

   localparam int NUM_ZONES_DEFAULT  = 8;
   localparam int COORD_BITS_DEFAULT = 12;

   localparam int ZONE_FIELD_BITS  = 3;
   localparam int SUM_BITS         = 32;
   localparam int COUNT_BITS       = 20;
   localparam int QUERY_BITS       = 12;

   // centroids are clamped to this width; any clamped value is out of range
   localparam int CENT_BITS        = 18;
   localparam int DIFF_BITS        = 17;
   localparam int SQ_BITS          = 2 * DIFF_BITS;
   localparam int DIST_BITS        = SQ_BITS + 1;

   localparam logic [CENT_BITS-1:0] DIST_LIMIT    = CENT_BITS'(100000);
   localparam logic [DIST_BITS-1:0] DIST_LIMIT_SQ = DIST_BITS'(64'd10000000000);
   localparam logic [CENT_BITS-1:0] CENT_MAX      = '1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                       cmd;
      logic [ZONE_FIELD_BITS-1:0] zone_index;
      logic [SUM_BITS-1:0]        sum_x_in;
      logic [SUM_BITS-1:0]        sum_y_in;
      logic [COUNT_BITS-1:0]      pixel_count_in;
      logic [QUERY_BITS-1:0]      query_x;
      logic [QUERY_BITS-1:0]      query_y;
   } req_type;

   typedef struct packed {
      logic                       found;
      logic [ZONE_FIELD_BITS-1:0] nearest_zone;
   } rsp_type;

   typedef struct packed {
      logic [CENT_BITS-1:0] cx;
      logic [CENT_BITS-1:0] cy;
   } cent_type;

endpackage

[src/nearest_centroid_query_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_query_unit: zone table with nearest centroid search
// Write items store a zone centroid; query items return the nearest zone.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on req_item and raise start; it is taken at the edge where
//   start is high and busy is low. Every item gives exactly one result item,
//   shown on rsp_item for one cycle with rsp_valid high. There is no stall on
//   the result side: the receiver must take it in that cycle.
//   Write with a zero pixel count, or to an index beyond the table: result in
//   the cycle after accept, busy never rises.
//   Write with a nonzero count: a radix-2 divider turns x-sum and y-sum into
//   the centroid, one quotient bit a cycle, then the store state writes it
//   to the centroid memory and gives the result.
//   Query: the centroid memory is read one zone a cycle through a four-stage
//   read / difference / square / compare pipeline; the result is registered
//   once the last zone has been compared.
//   busy is low in the cycle the result shows, so the next item may be taken
//   there. Reset (synchronous, active high) marks all zones empty through
//   per-zone flags; the centroid memory itself needs no clearing.
// ----------------------------------------------------------------------------
module nearest_centroid_query_unit #(
   parameter int NUM_ZONES  = ncq_pkg::NUM_ZONES_DEFAULT,
   parameter int COORD_BITS = ncq_pkg::COORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ncq_pkg::req_type req_item,
   output logic             rsp_valid,
   output ncq_pkg::rsp_type rsp_item
);
   import ncq_pkg::*;

   localparam int ZI_BITS  = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
   localparam int DIV_STEPS = SUM_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS);
   localparam logic [ZI_BITS-1:0]   LAST_ZONE = ZI_BITS'(NUM_ZONES - 1);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_STEPS - 1);
   localparam logic [QUERY_BITS-1:0] QUERY_MASK =
      (COORD_BITS >= QUERY_BITS) ? {QUERY_BITS{1'b1}}
                                 : QUERY_BITS'((1 << COORD_BITS) - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_STORE,
      ST_QUERY
   } state_type;

   // tag that travels with each zone down the query pipeline
   typedef struct packed {
      logic               valid;
      logic               live;
      logic               last;
      logic [ZI_BITS-1:0] idx;
   } tag_type;

   state_type state_ff;

   logic                 accept;
   logic                 idx_in_range;
   logic [NUM_ZONES-1:0] nonempty_ff;

   // divider
   logic [SUM_BITS-1:0]   dvd_x_ff, dvd_y_ff, dvd_x_in, dvd_y_in;
   logic [COUNT_BITS-1:0] rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [ZI_BITS-1:0]    widx_ff;
   logic [COUNT_BITS:0]   rsh_x, rsh_y;
   logic                  ge_x, ge_y;
   cent_type              wr_cent;

   // query
   cent_type              cent_mem [NUM_ZONES];
   cent_type              rd_data_ff;
   logic [QUERY_BITS-1:0] qx_ff, qy_ff;
   logic [ZI_BITS-1:0]    rd_idx_ff;
   logic                  issue_ff;
   tag_type               t1_ff, t2_ff, t3_ff;
   logic [CENT_BITS-1:0]  diff_x, diff_y;
   logic                  in_range;
   logic [DIFF_BITS-1:0]  dx_ff, dy_ff;
   logic [SQ_BITS-1:0]    sq_x_ff, sq_y_ff;
   logic [DIST_BITS-1:0]  d2;
   logic [DIST_BITS-1:0]  best_ff;
   logic [ZI_BITS-1:0]    best_idx_ff;
   logic                  found_ff;
   logic                  hit;
   logic                  found_in;
   logic [ZI_BITS-1:0]    best_idx_in;

   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign accept       = start && (state_ff == ST_IDLE);
   assign idx_in_range = 32'(req_item.zone_index) < NUM_ZONES;
   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_ff;

   // ---- restoring divider step, x and y side by side ----
   always_comb begin
      rsh_x    = {rem_x_ff, dvd_x_ff[SUM_BITS-1]};
      rsh_y    = {rem_y_ff, dvd_y_ff[SUM_BITS-1]};
      ge_x     = rsh_x >= {1'b0, cnt_ff};
      ge_y     = rsh_y >= {1'b0, cnt_ff};
      rem_x_in = ge_x ? COUNT_BITS'(rsh_x - {1'b0, cnt_ff}) : COUNT_BITS'(rsh_x);
      rem_y_in = ge_y ? COUNT_BITS'(rsh_y - {1'b0, cnt_ff}) : COUNT_BITS'(rsh_y);
      dvd_x_in = {dvd_x_ff[SUM_BITS-2:0], ge_x};
      dvd_y_in = {dvd_y_ff[SUM_BITS-2:0], ge_y};
   end

   // clamp the quotient: anything past CENT_MAX is out of range of any query
   always_comb begin
      wr_cent.cx = (dvd_x_ff > SUM_BITS'(CENT_MAX)) ? CENT_MAX : CENT_BITS'(dvd_x_ff);
      wr_cent.cy = (dvd_y_ff > SUM_BITS'(CENT_MAX)) ? CENT_MAX : CENT_BITS'(dvd_y_ff);
   end

   // ---- query pipeline: absolute difference ----
   always_comb begin
      diff_x   = (CENT_BITS'(qx_ff) >= rd_data_ff.cx) ? CENT_BITS'(qx_ff) - rd_data_ff.cx
                                                      : rd_data_ff.cx - CENT_BITS'(qx_ff);
      diff_y   = (CENT_BITS'(qy_ff) >= rd_data_ff.cy) ? CENT_BITS'(qy_ff) - rd_data_ff.cy
                                                      : rd_data_ff.cy - CENT_BITS'(qy_ff);
      in_range = (diff_x < DIST_LIMIT) && (diff_y < DIST_LIMIT);
   end

   // ---- query pipeline: sum of squares and running minimum ----
   always_comb begin
      d2          = DIST_BITS'(sq_x_ff) + DIST_BITS'(sq_y_ff);
      hit         = t3_ff.valid && t3_ff.live && (d2 < best_ff);
      found_in    = found_ff || hit;
      best_idx_in = hit ? t3_ff.idx : best_idx_ff;
   end

   // ---- centroid memory: one write port, one registered read port ----
   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) begin
         cent_mem[widx_ff] <= wr_cent;
      end
      rd_data_ff <= cent_mem[rd_idx_ff];
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      if (accept) begin
         dvd_x_ff <= req_item.sum_x_in;
         dvd_y_ff <= req_item.sum_y_in;
         rem_x_ff <= '0;
         rem_y_ff <= '0;
         cnt_ff   <= req_item.pixel_count_in;
         step_ff  <= '0;
         widx_ff  <= ZI_BITS'(req_item.zone_index);
         qx_ff    <= req_item.query_x & QUERY_MASK;
         qy_ff    <= req_item.query_y & QUERY_MASK;
      end else if (state_ff == ST_DIV) begin
         dvd_x_ff <= dvd_x_in;
         dvd_y_ff <= dvd_y_in;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         step_ff  <= step_ff + 1'b1;
      end
      dx_ff   <= DIFF_BITS'(diff_x);
      dy_ff   <= DIFF_BITS'(diff_y);
      sq_x_ff <= dx_ff * dx_ff;
      sq_y_ff <= dy_ff * dy_ff;
      if (hit) begin
         best_ff <= d2;
      end else if (accept) begin
         best_ff <= DIST_LIMIT_SQ;
      end
      best_idx_ff <= accept ? '0 : best_idx_in;
   end

   // ---- control: state, zone flags, pipeline tags, result ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nonempty_ff  <= '0;
         issue_ff     <= 1'b0;
         rd_idx_ff    <= '0;
         t1_ff        <= '0;
         t2_ff        <= '0;
         t3_ff        <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;

         // advance the query pipeline tags every cycle
         t1_ff.valid <= issue_ff;
         t1_ff.live  <= nonempty_ff[rd_idx_ff];
         t1_ff.last  <= issue_ff && (rd_idx_ff == LAST_ZONE);
         t1_ff.idx   <= rd_idx_ff;
         t2_ff       <= '{valid: t1_ff.valid,
                          live:  t1_ff.live && in_range,
                          last:  t1_ff.last,
                          idx:   t1_ff.idx};
         t3_ff       <= t2_ff;

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_item.cmd == CMD_QUERY) begin
                     rd_idx_ff <= '0;
                     issue_ff  <= 1'b1;
                     found_ff  <= 1'b0;
                     state_ff  <= ST_QUERY;
                  end else if (idx_in_range && (req_item.pixel_count_in != '0)) begin
                     state_ff <= ST_DIV;
                  end else begin
                     // empty or out-of-table write: answer at once
                     if (idx_in_range) begin
                        nonempty_ff[ZI_BITS'(req_item.zone_index)] <= 1'b0;
                     end
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '0;
                  end
               end
            end
            ST_DIV: begin
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_STORE;
               end
            end
            ST_STORE: begin
               nonempty_ff[widx_ff] <= 1'b1;
               rsp_valid_ff         <= 1'b1;
               rsp_ff               <= '0;
               state_ff             <= ST_IDLE;
            end
            ST_QUERY: begin
               if (issue_ff) begin
                  if (rd_idx_ff == LAST_ZONE) begin
                     issue_ff <= 1'b0;
                  end else begin
                     rd_idx_ff <= rd_idx_ff + 1'b1;
                  end
               end
               found_ff <= found_in;
               if (t3_ff.valid && t3_ff.last) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.found          <= found_in;
                  rsp_ff.nearest_zone   <= found_in ? ZONE_FIELD_BITS'(best_idx_in) : '0;
                  state_ff              <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[src/ncq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncq_checker: port-level checks for the nearest centroid query unit
// Watches the item handshake and result strobe over time.
// ----------------------------------------------------------------------------
module ncq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input ncq_pkg::req_type req_item,
   input logic             rsp_valid,
   input ncq_pkg::rsp_type rsp_item
);
   import ncq_pkg::*;

   // a result that found nothing carries zone zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.found) |-> (rsp_item.nearest_zone == '0))
      else $error("empty result carries a nonzero zone");

   // a query always takes the unit busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.cmd == CMD_QUERY)) |=> busy)
      else $error("query accepted without going busy");

   // an empty-zone write answers in the next cycle with nothing found
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.cmd == CMD_WRITE) && (req_item.pixel_count_in == '0))
      |=> (rsp_valid && !rsp_item.found && !busy))
      else $error("empty write did not answer at once");

   // no result without an item in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result with no item in flight");

   // reset leaves the unit idle with no result pending
   assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("unit not idle after reset");

endmodule

bind nearest_centroid_query_unit ncq_checker u_ncq_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for nearest_centroid_query_unit
// Drives zone writes and nearest-zone queries over the start/busy handshake,
// keeps a shadow zone table, and checks each result strobe in order against
// the predicted found flag and zone index. A short table of hand-picked items
// (empty table, distance limits, ties, extreme sums and counts) runs first,
// then about 1150 random items with bursts of idle cycles on the request side.
// ----------------------------------------------------------------------------
module tb_top;
   import ncq_pkg::*;

   localparam int              NUM_ZONES     = NUM_ZONES_DEFAULT;
   localparam longint unsigned SEARCH_RADIUS = 64'd100000;
   localparam longint unsigned RADIUS_SQ     = 64'd10000000000;
   localparam int              RANDOM_ITEMS  = 1150;
   // the last items run back to back, with no idle gaps
   localparam int              QUIET_TAIL    = 150;
   // longest wait for a result is a divided write
   localparam int              DRAIN_CYCLES  = 60;
   localparam int              CYCLE_LIMIT   = 400000;
   localparam rsp_type         NO_ZONE       = '0;

   typedef struct {
      req_type item;
      bit      typed;   // want is written out by hand
      rsp_type want;
   } dir_row_type;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   // shadow copy of the zone accumulators
   logic [SUM_BITS-1:0]   zone_sx  [NUM_ZONES];
   logic [SUM_BITS-1:0]   zone_sy  [NUM_ZONES];
   logic [COUNT_BITS-1:0] zone_cnt [NUM_ZONES];

   rsp_type     awaited_rsp [$];
   dir_row_type directed_rows [$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;

   nearest_centroid_query_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one item to the shadow table and return the result it should give.
   // A query takes the lowest zone whose centroid is strictly nearest and
   // strictly inside the search radius; a write always answers with no zone.
   function automatic rsp_type zone_search(input req_type it);
      rsp_type         r;
      longint unsigned qx, qy, cx, cy, dx, dy, d2, best;
      r = NO_ZONE;
      if (it.cmd == CMD_WRITE) begin
         zone_sx[it.zone_index]  = it.sum_x_in;
         zone_sy[it.zone_index]  = it.sum_y_in;
         zone_cnt[it.zone_index] = it.pixel_count_in;
         return r;
      end
      qx   = it.query_x;
      qy   = it.query_y;
      best = RADIUS_SQ;
      for (int z = 0; z < NUM_ZONES; z++) begin
         if (zone_cnt[z] == 0) continue;
         cx = zone_sx[z];
         cy = zone_sy[z];
         cx = cx / zone_cnt[z];
         cy = cy / zone_cnt[z];
         dx = (qx >= cx) ? qx - cx : cx - qx;
         dy = (qy >= cy) ? qy - cy : cy - qy;
         // far on either axis: drop before squaring
         if (dx >= SEARCH_RADIUS || dy >= SEARCH_RADIUS) continue;
         d2 = dx * dx + dy * dy;
         if (d2 < best) begin
            best           = d2;
            r.found        = 1'b1;
            r.nearest_zone = ZONE_FIELD_BITS'(z);
         end
      end
      return r;
   endfunction

   function automatic req_type write_item(input int zone, input logic [31:0] sx,
                                          input logic [31:0] sy, input int cnt);
      req_type it;
      it                = '0;
      it.cmd            = CMD_WRITE;
      it.zone_index     = ZONE_FIELD_BITS'(zone);
      it.sum_x_in       = sx;
      it.sum_y_in       = sy;
      it.pixel_count_in = COUNT_BITS'(cnt);
      return it;
   endfunction

   function automatic req_type query_item(input int qx, input int qy);
      req_type it;
      it         = '0;
      it.cmd     = CMD_QUERY;
      it.query_x = QUERY_BITS'(qx);
      it.query_y = QUERY_BITS'(qy);
      return it;
   endfunction

   task automatic add_row(input req_type it, input bit typed, input rsp_type want);
      dir_row_type row;
      row.item  = it;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // Random item. Every field gets random bits first, so the fields an item
   // does not use still toggle; then shape writes toward centroids inside the
   // query range and queries toward stored centroids.
   function automatic req_type random_item();
      req_type         it;
      longint unsigned cnt, cx, cy, sx, sy;
      int              j, qx, qy, pick;
      it.cmd            = ($urandom_range(0, 9) < 6) ? CMD_QUERY : CMD_WRITE;
      it.zone_index     = ZONE_FIELD_BITS'($urandom_range(0, NUM_ZONES - 1));
      it.sum_x_in       = $urandom();
      it.sum_y_in       = $urandom();
      it.pixel_count_in = COUNT_BITS'($urandom_range(0, 1048575));
      it.query_x        = QUERY_BITS'($urandom_range(0, 4095));
      it.query_y        = QUERY_BITS'($urandom_range(0, 4095));
      pick = $urandom_range(0, 99);
      j    = $urandom_range(0, NUM_ZONES - 1);
      if (it.cmd == CMD_WRITE) begin
         if (pick < 10) begin
            it.pixel_count_in = '0;            // empty the zone
         end else if (pick < 20) begin
            // raw noise: leave the random sums and count
         end else if (pick < 30) begin
            // copy another zone so equal distances come up
            it.sum_x_in       = zone_sx[j];
            it.sum_y_in       = zone_sy[j];
            it.pixel_count_in = zone_cnt[j];
         end else begin
            cnt = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 1048575);
            cx  = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, 120000);
            cy  = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, 120000);
            sx  = cx * cnt + $urandom_range(0, 32'(cnt - 1));
            sy  = cy * cnt + $urandom_range(0, 32'(cnt - 1));
            it.pixel_count_in = COUNT_BITS'(cnt);
            if (sx <= 64'hFFFF_FFFF) it.sum_x_in = sx[31:0];
            if (sy <= 64'hFFFF_FFFF) it.sum_y_in = sy[31:0];
         end
      end else if (pick < 40 && zone_cnt[j] != 0) begin
         // aim near a stored centroid, clamped into the coordinate range
         cx = zone_sx[j];
         cy = zone_sy[j];
         cx = cx / zone_cnt[j];
         cy = cy / zone_cnt[j];
         if (cx < 5000 && cy < 5000) begin
            qx = int'(cx) + int'($urandom_range(0, 6)) - 3;
            qy = int'(cy) + int'($urandom_range(0, 6)) - 3;
            qx = (qx < 0) ? 0 : (qx > 4095) ? 4095 : qx;
            qy = (qy < 0) ? 0 : (qy > 4095) ? 4095 : qy;
            it.query_x = QUERY_BITS'(qx);
            it.query_y = QUERY_BITS'(qy);
         end
      end
      return it;
   endfunction

   // Offer one item, optionally after an idle burst, and hold it until the
   // edge where start is high and busy is low. Queue its result at that edge.
   task automatic send_item(input req_type it, input bit typed, input rsp_type want,
                            input bit may_idle);
      rsp_type predicted;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      predicted = zone_search(it);
      awaited_rsp.push_back(typed ? want : predicted);
   endtask

   // Check each result strobe against the oldest waiting prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            $error("result with none pending: found=%0b nearest_zone=%0d",
                   rsp_item.found, rsp_item.nearest_zone);
            mismatch_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_item.found !== want.found) begin
               $error("found: expected %0b, actual %0b", want.found, rsp_item.found);
               mismatch_count++;
            end
            if (rsp_item.nearest_zone !== want.nearest_zone) begin
               $error("nearest_zone: expected %0d, actual %0d",
                      want.nearest_zone, rsp_item.nearest_zone);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      rsp_type hit;
      bit      idle_ok;

      for (int z = 0; z < NUM_ZONES; z++) begin
         zone_sx[z]  = '0;
         zone_sy[z]  = '0;
         zone_cnt[z] = '0;
      end

      // Empty table: no zone at either corner of the query range.
      add_row(query_item(0, 0), 1'b1, NO_ZONE);
      add_row(query_item(4095, 4095), 1'b1, NO_ZONE);
      // A zero-count write leaves the zone empty.
      add_row(write_item(0, 0, 0, 0), 1'b1, NO_ZONE);
      add_row(query_item(0, 0), 1'b1, NO_ZONE);
      // Axis limit: centroid x = 104094, so dx is 99999 from 4095, 100000 from 4094.
      add_row(write_item(5, 104094, 4095, 1), 1'b1, NO_ZONE);
      add_row(query_item(4095, 4095), 1'b0, NO_ZONE);
      add_row(query_item(4094, 4095), 1'b0, NO_ZONE);
      // Squared limit on the diagonal: dx = dy = 70710 is inside, 70711 is not.
      add_row(write_item(5, 74805 * 3, 74805 * 3 + 2, 3), 1'b1, NO_ZONE);
      add_row(query_item(4095, 4095), 1'b0, NO_ZONE);
      add_row(query_item(4094, 4094), 1'b0, NO_ZONE);
      // Largest sums over one pixel: centroid far off, never chosen.
      add_row(write_item(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 1'b1, NO_ZONE);
      add_row(query_item(4095, 0), 1'b0, NO_ZONE);
      // Largest sums over the largest count: centroid just past the corner.
      add_row(write_item(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1048575), 1'b1, NO_ZONE);
      add_row(query_item(4095, 4095), 1'b0, NO_ZONE);
      // Equal distance: zones 1 and 3 share a centroid, the lower index wins.
      add_row(write_item(3, 500, 1000, 5), 1'b1, NO_ZONE);
      add_row(write_item(1, 100, 200, 1), 1'b1, NO_ZONE);
      hit.found        = 1'b1;
      hit.nearest_zone = 3'd1;
      add_row(query_item(100, 200), 1'b1, hit);
      // Empty zone 1 again; zone 3 takes over.
      add_row(write_item(1, 100, 200, 0), 1'b1, NO_ZONE);
      hit.nearest_zone = 3'd3;
      add_row(query_item(100, 200), 1'b1, hit);
      add_row(query_item(0, 0), 1'b0, NO_ZONE);
      add_row(write_item(2, 0, 0, 1), 1'b1, NO_ZONE);
      hit.nearest_zone = 3'd2;
      add_row(query_item(0, 0), 1'b1, hit);
      // Truncating division: (28671 / 7, 14336 / 7) = (4095, 2048).
      add_row(write_item(6, 4095 * 7 + 6, 2048 * 7, 7), 1'b1, NO_ZONE);
      add_row(query_item(4095, 2048), 1'b0, NO_ZONE);

      // Hold reset, then release.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed,
                   directed_rows[i].want, 1'b1);

      // Random part: idle bursts in two of every three stretches of 120 items,
      // none in the tail.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_ok = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 120) % 3 != 1);
         send_item(random_item(), 1'b0, NO_ZONE, idle_ok);
      end

      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      // Let any stray result show before closing.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
